[design/tga_rle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pkg: shared types and constants of the tga rle pixel decoder
// pixel format codes, register indexes, color word type, 5-bit widening
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  // pixel format codes
  localparam logic [1:0] FMT_INDEX8 = 2'd0;
  localparam logic [1:0] FMT_RGB555 = 2'd1;
  localparam logic [1:0] FMT_BGR24  = 2'd2;
  localparam logic [1:0] FMT_BGRA32 = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] REG_ALPHA_ENABLE = 3'd1;
  localparam logic [2:0] REG_ROW_WIDTH    = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_MIRROR_X     = 3'd4;
  localparam logic [2:0] REG_BOTTOM_UP    = 3'd5;
  localparam logic [2:0] REG_RLE_ENABLE   = 3'd6;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [7:0] index_or_blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } pix_color_t;

  // 5-bit channel to 8 bits by bit replication
  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

endpackage

[design/tga_rle_pixel_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top: tga pixel data decoder with rle packets
// takes one pixel data byte per word, gives one word per pixel or repeat run
// ----------------------------------------------------------------------------
// datapath: a byte is registered in the input stage and decoded from there;
//   its result word is then registered in the result register
// throughput: one byte per cycle while the result channel does not stall, set by
//   the single decode stage that updates the packet, byte and position counters
// reset: synchronous active-low rst_n clears all counters, empties both
//   stages and loads the register reset values (24-bit bgr, bottom-up rows)
module tga_rle_pixel_decoder_top
  import tga_rle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // byte input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_index_or_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_alpha,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [7:0]  out_run_count,
  output logic        out_row_end,
  output logic        out_image_end
);

  // configuration registers
  logic [1:0]  pixel_format_r;
  logic        alpha_enable_r;
  logic [15:0] row_width_r;
  logic [15:0] image_height_r;
  logic        mirror_x_r;
  logic        bottom_up_r;
  logic        rle_enable_r;

  // input stage
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;

  // decode state
  logic [7:0]  repeat_left_r, repeat_left_nxt;
  logic [7:0]  raw_left_r, raw_left_nxt;
  logic [1:0]  byte_phase_r, byte_phase_nxt;
  logic [31:0] pixel_bytes_r, pixel_bytes_nxt;
  logic [15:0] column_count_r, column_count_nxt;
  logic [15:0] row_count_r, row_count_nxt;

  // result register
  logic        out_valid_r;
  pix_color_t  color_r;
  logic [15:0] pos_x_r, pos_y_r;
  logic [7:0]  run_count_r;
  logic        row_end_r, image_end_r;

  // decode signals
  logic        is_header;
  logic        pix_done;
  logic        emit;
  logic        advance;
  logic        out_free;
  logic [31:0] bytes_acc;
  logic [15:0] w_eff, h_eff;
  logic [15:0] remaining;
  logic [7:0]  cnt;
  logic        rend, iend;
  logic [16:0] row_inc;
  logic [15:0] px, py;
  pix_color_t  color;

  // cfg port never stalls; user sends writes only when block is idle, unchecked
  assign cfg_ready = 1'b1;

  // with rle on, a byte at a packet boundary is a header
  assign is_header = rle_enable_r && (repeat_left_r == '0) && (raw_left_r == '0);

  // byte k of the pixel lands at bit 8k, first byte clears the rest
  always_comb begin
    bytes_acc = (byte_phase_r == 2'd0) ? 32'd0 : pixel_bytes_r;
    case (byte_phase_r)
      2'd0:    bytes_acc[7:0]   = s1_byte_r;
      2'd1:    bytes_acc[15:8]  = s1_byte_r;
      2'd2:    bytes_acc[23:16] = s1_byte_r;
      2'd3:    bytes_acc[31:24] = s1_byte_r;
      default: bytes_acc[7:0]   = s1_byte_r;
    endcase
  end

  // pixel completes once phase reaches the byte count minus one
  assign pix_done = !is_header && !(byte_phase_r < pixel_format_r);
  assign emit     = pix_done;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && (out_free || !emit);
  assign in_ready = !s1_valid_r || advance;

  tga_rle_unpack u_unpack (
    .fmt       (pixel_format_r),
    .alpha_en  (alpha_enable_r),
    .pix_bytes (bytes_acc),
    .color     (color)
  );

  // zero width or height acts as one
  assign w_eff = (row_width_r == '0) ? 16'd1 : row_width_r;
  assign h_eff = (image_height_r == '0) ? 16'd1 : image_height_r;

  // pixels left in the row, one when the column ran past a lowered width
  assign remaining = (column_count_r < w_eff) ? (w_eff - column_count_r) : 16'd1;

  // repeat run is clipped to the row
  always_comb begin
    cnt = 8'd1;
    if (rle_enable_r && (repeat_left_r != '0)) begin
      if ({8'd0, repeat_left_r} < remaining) cnt = repeat_left_r;
      else cnt = remaining[7:0];
    end
  end

  assign rend    = ({8'd0, cnt} >= remaining);
  assign row_inc = {1'b0, row_count_r} + 17'd1;
  assign iend    = rend && (row_inc >= {1'b0, h_eff});

  // screen position with both flips
  assign px = mirror_x_r ? (w_eff - 16'd1 - column_count_r) : column_count_r;
  assign py = bottom_up_r ? (h_eff - 16'd1 - row_count_r) : row_count_r;

  // next decode state
  always_comb begin
    repeat_left_nxt  = repeat_left_r;
    raw_left_nxt     = raw_left_r;
    byte_phase_nxt   = byte_phase_r;
    pixel_bytes_nxt  = pixel_bytes_r;
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (is_header) begin
      // header byte opens a repeat or raw packet
      if (s1_byte_r[7]) repeat_left_nxt = {1'b0, s1_byte_r[6:0]} + 8'd1;
      else raw_left_nxt = s1_byte_r + 8'd1;
      byte_phase_nxt  = 2'd0;
      pixel_bytes_nxt = '0;
    end else begin
      pixel_bytes_nxt = bytes_acc;
      if (!pix_done) begin
        byte_phase_nxt = byte_phase_r + 2'd1;
      end else begin
        byte_phase_nxt = 2'd0;
        if (rle_enable_r && (repeat_left_r != '0)) begin
          repeat_left_nxt = '0;
        end else if (rle_enable_r && (raw_left_r != '0)) begin
          raw_left_nxt = raw_left_r - 8'd1;
        end else begin
          // rle off: stale packet counters are dropped
          repeat_left_nxt = '0;
          raw_left_nxt    = '0;
        end
        if (rend) begin
          // packets are cut off at the end of the row
          column_count_nxt = '0;
          repeat_left_nxt  = '0;
          raw_left_nxt     = '0;
          row_count_nxt    = iend ? 16'd0 : row_inc[15:0];
        end else begin
          column_count_nxt = column_count_r + {8'd0, cnt};
        end
      end
    end
  end

  // config registers and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= FMT_BGR24;
      alpha_enable_r <= 1'b0;
      row_width_r    <= 16'd1;
      image_height_r <= 16'd1;
      mirror_x_r     <= 1'b0;
      bottom_up_r    <= 1'b1;
      rle_enable_r   <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      repeat_left_r  <= '0;
      raw_left_r     <= '0;
      byte_phase_r   <= '0;
      pixel_bytes_r  <= '0;
      column_count_r <= '0;
      row_count_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PIXEL_FORMAT: pixel_format_r <= cfg_data[1:0];
          REG_ALPHA_ENABLE: alpha_enable_r <= cfg_data[0];
          REG_ROW_WIDTH:    row_width_r    <= cfg_data;
          REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
          REG_MIRROR_X:     mirror_x_r     <= cfg_data[0];
          REG_BOTTOM_UP:    bottom_up_r    <= cfg_data[0];
          REG_RLE_ENABLE:   rle_enable_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      // input stage fills on accept, drains on advance
      if (in_valid && in_ready) s1_valid_r <= 1'b1;
      else if (advance) s1_valid_r <= 1'b0;
      // result word held until taken
      if (advance && emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (advance) begin
        repeat_left_r  <= repeat_left_nxt;
        raw_left_r     <= raw_left_nxt;
        byte_phase_r   <= byte_phase_nxt;
        pixel_bytes_r  <= pixel_bytes_nxt;
        column_count_r <= column_count_nxt;
        row_count_r    <= row_count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte_r <= in_stream_byte;
    if (advance && emit) begin
      color_r     <= color;
      pos_x_r     <= px;
      pos_y_r     <= py;
      run_count_r <= cnt;
      row_end_r   <= rend;
      image_end_r <= iend;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_index_or_blue = color_r.index_or_blue;
  assign out_green         = color_r.green;
  assign out_red           = color_r.red;
  assign out_alpha         = color_r.alpha;
  assign out_pos_x         = pos_x_r;
  assign out_pos_y         = pos_y_r;
  assign out_run_count     = run_count_r;
  assign out_row_end       = row_end_r;
  assign out_image_end     = image_end_r;

endmodule

[design/tga_rle_unpack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_unpack: pixel byte unpacker
// turns the gathered pixel bytes into index/blue, green, red and alpha
// ----------------------------------------------------------------------------
module tga_rle_unpack
  import tga_rle_pkg::*;
(
  input  logic [1:0]  fmt,
  input  logic        alpha_en,
  input  logic [31:0] pix_bytes,
  output pix_color_t  color
);

  logic [15:0] c555;

  assign c555 = pix_bytes[15:0];

  always_comb begin
    color.index_or_blue = pix_bytes[7:0];
    color.green         = pix_bytes[15:8];
    color.red           = pix_bytes[23:16];
    color.alpha         = ALPHA_OPAQUE;
    case (fmt)
      FMT_INDEX8: begin
        color.green = '0;
        color.red   = '0;
      end
      FMT_RGB555: begin
        color.index_or_blue = widen5(c555[4:0]);
        color.green         = widen5(c555[9:5]);
        color.red           = widen5(c555[14:10]);
      end
      FMT_BGR24: begin
      end
      FMT_BGRA32: begin
        if (alpha_en) color.alpha = pix_bytes[31:24];
      end
      default: begin
      end
    endcase
  end

endmodule

[design/tga_rle_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_checker: port-level checks of the tga rle pixel decoder
// watches the result channel over time, bound to the top level
// ----------------------------------------------------------------------------
module tga_rle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pos_x,
  input logic [15:0] out_pos_y,
  input logic [7:0]  out_run_count,
  input logic        out_row_end,
  input logic        out_image_end
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) &&
      $stable(out_pos_y) && $stable(out_run_count) && $stable(out_image_end))
    else $error("result word changed while stalled");

  // run count is always within one packet
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_count != 8'd0) && (out_run_count <= 8'd128))
    else $error("run count out of range");

  // image end only on the last run of a row
  a_image_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_row_end)
    else $error("image end without row end");

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tga_rle_pixel_decoder_top tga_rle_checker u_tga_rle_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_pos_x     (out_pos_x),
  .out_pos_y     (out_pos_y),
  .out_run_count (out_run_count),
  .out_row_end   (out_row_end),
  .out_image_end (out_image_end)
);

[tb/sv/tb_tga_rle_pixel_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_top: self-checking bench of the tga rle decoder
// feeds pixel data bytes, models the decoder behaviorally and compares every run
// word against it or a pinned word, under varied settings and backpressure
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_top;
  import tga_rle_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;    // covers the two-stage pipe with margin
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_BYTES  = 135;

  // one run word as the decoder gives it
  typedef struct packed {
    logic [7:0]  blue_idx;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  count;
    logic        row_last;
    logic        image_last;
  } pix_run_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  // directed stimulus row: a register write or a byte, the latter with an
  // optional hand-written run word that replaces the model's guess
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    logic [7:0]  data;
    logic        pinned;
    pix_run_t    run;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_index_or_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [7:0]  out_alpha;
  logic [15:0] out_pos_x;
  logic [15:0] out_pos_y;
  logic [7:0]  out_run_count;
  logic        out_row_end;
  logic        out_image_end;

  // hand-written expectation riding along with the byte being offered
  logic        pin_use = 1'b0;
  pix_run_t    pin_run = '0;

  tga_rle_pixel_decoder_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_index_or_blue(out_index_or_blue),
    .out_green        (out_green),
    .out_red          (out_red),
    .out_alpha        (out_alpha),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_run_count    (out_run_count),
    .out_row_end      (out_row_end),
    .out_image_end    (out_image_end)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // decoder model: register copies and packet / pixel / position state
  // ---------------------------------------------------------------------------
  logic [1:0]  dec_fmt = FMT_BGR24;
  logic        dec_alpha_en = 1'b0;
  logic [15:0] dec_width = 16'd1;
  logic [15:0] dec_height = 16'd1;
  logic        dec_mirror = 1'b0;
  logic        dec_bottom_up = 1'b1;
  logic        dec_rle = 1'b0;

  logic [7:0]  rep_left = '0;     // copies left in the open repeat packet
  logic [7:0]  raw_left = '0;     // pixels left in the open raw packet
  logic [1:0]  byte_phase = '0;   // bytes of the pixel taken so far
  logic [31:0] pix_bytes = '0;
  logic [15:0] col = '0;
  logic [15:0] row = '0;

  pix_run_t    pending_runs[$];   // run words still owed by the decoder
  pix_run_t    got_run;
  pix_run_t    want_run;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  stim_row_t   dir_rows[$];

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, 3'b000} | 8'(v >> 2);
  endfunction

  // advance the model by one byte; returns 1 when a run word comes out
  function automatic bit decode_byte(input logic [7:0] b, output pix_run_t run);
    int unsigned need;
    int unsigned w;
    int unsigned h;
    int unsigned remaining;
    int unsigned cnt;
    logic [15:0] c555;
    run = '0;
    // packet boundary: this byte is a header
    if (dec_rle && rep_left == 0 && raw_left == 0) begin
      if (b >= 8'd128) rep_left = b - 8'd127;
      else raw_left = b + 8'd1;
      byte_phase = '0;
      pix_bytes = '0;
      return 1'b0;
    end
    if (byte_phase == 0) pix_bytes = '0;
    pix_bytes |= 32'(b) << (8 * byte_phase);
    need = 32'(dec_fmt) + 1;
    if (32'(byte_phase) + 1 < need) begin
      byte_phase = byte_phase + 2'd1;
      return 1'b0;
    end
    byte_phase = '0;

    run.alpha = ALPHA_OPAQUE;
    case (dec_fmt)
      FMT_INDEX8: begin
        run.blue_idx = pix_bytes[7:0];
      end
      FMT_RGB555: begin
        c555 = pix_bytes[15:0];
        run.blue_idx = expand5(c555[4:0]);
        run.green    = expand5(c555[9:5]);
        run.red      = expand5(c555[14:10]);
      end
      FMT_BGR24: begin
        run.blue_idx = pix_bytes[7:0];
        run.green    = pix_bytes[15:8];
        run.red      = pix_bytes[23:16];
      end
      default: begin
        run.blue_idx = pix_bytes[7:0];
        run.green    = pix_bytes[15:8];
        run.red      = pix_bytes[23:16];
        if (dec_alpha_en) run.alpha = pix_bytes[31:24];
      end
    endcase

    // zero sizes act as one; a column past the width leaves one pixel
    w = (dec_width == 0) ? 1 : 32'(dec_width);
    h = (dec_height == 0) ? 1 : 32'(dec_height);
    remaining = (32'(col) < w) ? (w - 32'(col)) : 1;

    if (dec_rle && rep_left != 0) begin
      cnt = (32'(rep_left) < remaining) ? 32'(rep_left) : remaining;
      rep_left = '0;
    end else if (dec_rle && raw_left != 0) begin
      cnt = 1;
      raw_left = raw_left - 8'd1;
    end else begin
      // plain bytes, any leftover packet is dropped
      cnt = 1;
      rep_left = '0;
      raw_left = '0;
    end

    run.x = dec_mirror ? 16'(w - 1 - 32'(col)) : col;
    run.y = dec_bottom_up ? 16'(h - 1 - 32'(row)) : row;
    run.count = 8'(cnt);
    run.row_last = (cnt >= remaining);
    run.image_last = 1'b0;
    if (run.row_last) begin
      col = '0;
      rep_left = '0;
      raw_left = '0;
      if (32'(row) + 1 >= h) begin
        run.image_last = 1'b1;
        row = '0;
      end else begin
        row = row + 16'd1;
      end
    end else begin
      col = col + 16'(cnt);
    end
    return 1'b1;
  endfunction

  task automatic cmp_field(input string name, input logic [15:0] want,
                           input logic [15:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: follows register writes and accepted bytes, checks run words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PIXEL_FORMAT: dec_fmt       = cfg_data[1:0];
          REG_ALPHA_ENABLE: dec_alpha_en  = cfg_data[0];
          REG_ROW_WIDTH:    dec_width     = cfg_data;
          REG_IMAGE_HEIGHT: dec_height    = cfg_data;
          REG_MIRROR_X:     dec_mirror    = cfg_data[0];
          REG_BOTTOM_UP:    dec_bottom_up = cfg_data[0];
          REG_RLE_ENABLE:   dec_rle       = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_stream_byte, got_run))
          pending_runs.insert(pending_runs.size(), pin_use ? pin_run : got_run);
      end
      if (out_valid && out_ready) begin
        if (pending_runs.size() == 0) begin
          $display("%0t: run word with nothing expected, actual x %0h y %0h",
                   $time, out_pos_x, out_pos_y);
          err_cnt++;
        end else begin
          want_run = pending_runs.pop_front();
          cmp_field("index_or_blue", 16'(want_run.blue_idx), 16'(out_index_or_blue));
          cmp_field("green", 16'(want_run.green), 16'(out_green));
          cmp_field("red", 16'(want_run.red), 16'(out_red));
          cmp_field("alpha", 16'(want_run.alpha), 16'(out_alpha));
          cmp_field("pos_x", want_run.x, out_pos_x);
          cmp_field("pos_y", want_run.y, out_pos_y);
          cmp_field("run_count", 16'(want_run.count), 16'(out_run_count));
          cmp_field("row_end", 16'(want_run.row_last), 16'(out_row_end));
          cmp_field("image_end", 16'(want_run.image_last), 16'(out_image_end));
        end
      end
    end
  end

  // receiver backpressure, driven by the current stall rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one byte, with random idle cycles before it, and wait until it is taken
  task automatic push_byte(input logic [7:0] b, input logic pin,
                           input pix_run_t run);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    pin_use        <= pin;
    pin_run        <= run;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // register write; valid stays high, the caller drops it after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stop sending, wait for every owed word, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [15:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic add_byte(input logic [7:0] b);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.data = b;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic add_pinned(input logic [7:0] b, input logic [7:0] bl,
                            input logic [7:0] g, input logic [7:0] rd,
                            input logic [7:0] a, input logic [15:0] x,
                            input logic [15:0] y, input logic [7:0] cnt,
                            input logic rl, input logic il);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.data = b;
    r.pinned = 1'b1;
    r.run = '{blue_idx: bl, green: g, red: rd, alpha: a, x: x, y: y,
              count: cnt, row_last: rl, image_last: il};
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // random pixel byte, leaning toward the extremes now and then
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit          in_cfg;
    int          sent;
    int          bpp;
    int          npix;
    int          sel;
    int          room;
    logic [1:0]  fmt;
    logic        rle;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  hdr;

    // --- directed rows ---
    // reset setting: bgr 24, one by one image, bottom-up
    add_byte(8'h11);
    add_byte(8'h22);
    add_pinned(8'h33, 8'h11, 8'h22, 8'h33, ALPHA_OPAQUE, 16'd0, 16'd0, 8'd1, 1'b1, 1'b1);
    // index format, 4x2, top-down, rle packets
    add_cfg(REG_PIXEL_FORMAT, 16'(FMT_INDEX8));
    add_cfg(REG_ALPHA_ENABLE, 16'd0);
    add_cfg(REG_ROW_WIDTH, 16'd4);
    add_cfg(REG_IMAGE_HEIGHT, 16'd2);
    add_cfg(REG_MIRROR_X, 16'd0);
    add_cfg(REG_BOTTOM_UP, 16'd0);
    add_cfg(REG_RLE_ENABLE, 16'd1);
    // a four-pixel repeat fills the row exactly
    add_byte(8'h83);
    add_pinned(8'h00, 8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 16'd0, 16'd0, 8'd4, 1'b1, 1'b0);
    // largest repeat gets cut at the row end, which also ends the image
    add_byte(8'hff);
    add_pinned(8'hff, 8'hff, 8'h00, 8'h00, ALPHA_OPAQUE, 16'd0, 16'd1, 8'd4, 1'b1, 1'b1);
    // largest raw packet, two pixels in
    add_byte(8'h7f);
    add_pinned(8'haa, 8'haa, 8'h00, 8'h00, ALPHA_OPAQUE, 16'd0, 16'd0, 8'd1, 1'b0, 1'b0);
    add_byte(8'h55);
    // width lowered below the column mid-row
    add_cfg(REG_ROW_WIDTH, 16'd1);
    add_byte(8'h3c);
    // 555, zero width and height, mirrored, plain bytes; row is past height
    add_cfg(REG_PIXEL_FORMAT, 16'(FMT_RGB555));
    add_cfg(REG_ROW_WIDTH, 16'd0);
    add_cfg(REG_IMAGE_HEIGHT, 16'd0);
    add_cfg(REG_MIRROR_X, 16'd1);
    add_cfg(REG_BOTTOM_UP, 16'd1);
    add_cfg(REG_RLE_ENABLE, 16'd0);
    add_byte(8'hff);
    add_byte(8'hff);
    // bit 15 set is ignored
    add_byte(8'h00);
    add_pinned(8'h80, 8'h00, 8'h00, 8'h00, ALPHA_OPAQUE, 16'd0, 16'd0, 8'd1, 1'b1, 1'b1);
    // bgra with alpha taken, tallest image
    add_cfg(REG_PIXEL_FORMAT, 16'(FMT_BGRA32));
    add_cfg(REG_ALPHA_ENABLE, 16'd1);
    add_cfg(REG_ROW_WIDTH, 16'd3);
    add_cfg(REG_IMAGE_HEIGHT, 16'hffff);
    add_cfg(REG_MIRROR_X, 16'd0);
    add_byte(8'h01);
    add_byte(8'h02);
    add_byte(8'h03);
    add_pinned(8'h00, 8'h01, 8'h02, 8'h03, 8'h00, 16'd0, 16'hfffe, 8'd1, 1'b0, 1'b0);
    // format switched with one byte of a pixel taken
    add_byte(8'h12);
    add_cfg(REG_PIXEL_FORMAT, 16'(FMT_INDEX8));
    add_byte(8'h34);
    // repeat packet opened, then rle turned off
    add_cfg(REG_RLE_ENABLE, 16'd1);
    add_byte(8'h85);
    add_cfg(REG_RLE_ENABLE, 16'd0);
    add_byte(8'h77);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    in_cfg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!in_cfg) wait_idle();
        in_cfg = 1'b1;
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        if (in_cfg) cfg_valid <= 1'b0;
        in_cfg = 1'b0;
        push_byte(dir_rows[i].data, dir_rows[i].pinned, dir_rows[i].run);
      end
    end

    // --- random phases ---
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      // idle pattern: none, sender idle, receiver stall, both
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 67; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 67; end
        default: begin gap_pct = 19; stall_pct = 19; end
      endcase

      fmt = 2'($urandom_range(3));
      rle = ($urandom_range(3) != 0);
      case ($urandom_range(9))
        0: width = 16'd0;
        1: width = 16'hffff;
        2: width = 16'($urandom_range(1, 65535));
        3: width = 16'd200;   // room for full 128-pixel runs
        default: width = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(9))
        0: height = 16'd0;
        1: height = 16'hffff;
        2: height = 16'($urandom_range(1, 65535));
        default: height = 16'($urandom_range(1, 4));
      endcase
      if (ph == 1) begin
        width  = 16'hffff;
        height = 16'hffff;
      end
      write_reg(REG_PIXEL_FORMAT, 16'(fmt));
      write_reg(REG_ALPHA_ENABLE, 16'($urandom_range(1)));
      write_reg(REG_ROW_WIDTH, width);
      write_reg(REG_IMAGE_HEIGHT, height);
      write_reg(REG_MIRROR_X, (ph == 1) ? 16'd1 : 16'($urandom_range(1)));
      write_reg(REG_BOTTOM_UP, (ph == 1) ? 16'd1 : 16'($urandom_range(1)));
      write_reg(REG_RLE_ENABLE, 16'(rle));
      cfg_valid <= 1'b0;

      bpp = int'(fmt) + 1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        sel = $urandom_range(19);
        if (ph == 2 && sent >= 60 && sent < 70) begin
          // hold the sender until every owed word is out
          wait_idle();
          sent = 70;
        end
        if (sel == 0) begin
          // noise byte, may land mid-packet or mid-pixel
          push_byte(8'($urandom), 1'b0, '0);
          sent++;
        end else if (!rle) begin
          repeat (bpp) push_byte(rand_byte(), 1'b0, '0);
          sent += bpp;
        end else begin
          if (sel < 8) begin
            hdr = 8'($urandom_range(128, 255));
          end else if (sel == 8) begin
            // raw packet sized to what is left of the phase budget
            room = (PHASE_BYTES - sent) / bpp;
            if (room > 128) room = 128;
            if (room < 1) room = 1;
            hdr = 8'($urandom_range(0, room - 1));
          end else begin
            hdr = 8'($urandom_range(0, 3));
          end
          push_byte(hdr, 1'b0, '0);
          npix = (hdr >= 8'd128) ? 1 : int'(hdr) + 1;
          // occasionally a packet is cut short
          if (sel == 9 && npix > 1) npix = $urandom_range(1, npix - 1);
          repeat (npix * bpp) push_byte(rand_byte(), 1'b0, '0);
          sent += 1 + npix * bpp;
        end
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
